// ----- hdl/amr_fg_pkg.sv -----
// Package for the fine-grid remap block: field widths, codes and the
// control structs passed between the sequencer, the accumulator and the top.
// No dependencies.
package amr_fg_pkg;

    localparam int LEVEL_W    = 4;   // cell_level and max_level
    localparam int COORD_W    = 8;   // col and row
    localparam int BASE_W     = 9;   // base_cols and base_rows
    localparam int IN_VALUE_W = 32;  // cell_value on the stream
    localparam int MEAN_W     = 32;  // mean_value on the stream
    localparam int SHIFT_W    = 5;   // 2*(max_level - cell_level)
    // Position width for bounds math: 8-bit coordinate shifted by up to 15, plus one side.
    localparam int POS_W      = 25;

    localparam int CFG_W      = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ROWS = 2'd2;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic clear;  // zero the sum at the start of a query
        logic add;    // memory read data is valid this cycle
    } acc_ctrl_t;

    typedef struct packed {
        logic valid;  // result ready to load into the output register
        logic error;  // level or block out of range
        logic query;  // item was a query
    } done_t;

endpackage

// ----- hdl/amr_fine_grid_remap_top.sv -----
// Top level of the fine-grid remap block: configuration registers, stream
// ports and the output register. Depends on amr_fg_pkg, amr_fg_walker,
// amr_fg_store and amr_fg_accum.
//
// Usage:
//   Write max_level, base_cols and base_rows through cfg_wr_en/cfg_addr/cfg_wdata
//   while the block is idle. Send items on the s_ stream: a load (tuser 0)
//   fills every fine cell under the cell with its value, a query (tuser 1)
//   returns the floor mean of the fine cells under the cell.
//   Each item yields one result item on the m_ stream; tuser flags an
//   out-of-range level or block, and then the mean is zero (it is always
//   zero for loads).
// Timing:
//   s_tready is high only between items. With side = 2^(max_level-cell_level)
//   an in-range item walks side*side fine cells, one memory access per cycle
//   on the single store port. After acceptance an item passes the check
//   state, the walk, a drain state for a query, and the finish state that loads
//   the output register; an item in error goes straight from check to finish.
// Reset and stall:
//   aresetn clears the sequencer, the output valid and the registers to
//   max_level 0, base_cols 1, base_rows 1; the store is not cleared and must
//   be loaded before it is queried. A stalled result holds in the output
//   register; a new item is accepted meanwhile and waits at its end until
//   the output register frees.
module amr_fine_grid_remap_top #(
    parameter int FINE_SIDE_BITS = 8,
    parameter int VALUE_BITS     = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [amr_fg_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [amr_fg_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [55:0]                        s_tdata,  // cell_level[3:0], col[11:4],
                                                         // row[19:12], cell_value[51:20]
    input  logic                               s_tuser,  // mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,  // mean_value[31:0]
    output logic                               m_tuser   // error
);

    logic [amr_fg_pkg::LEVEL_W-1:0] max_level_reg;
    logic [amr_fg_pkg::BASE_W-1:0]  base_cols_reg;
    logic [amr_fg_pkg::BASE_W-1:0]  base_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_level_reg <= '0;
            base_cols_reg <= amr_fg_pkg::BASE_W'(1);
            base_rows_reg <= amr_fg_pkg::BASE_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                amr_fg_pkg::CFG_MAX_LEVEL: max_level_reg <= cfg_wdata[amr_fg_pkg::LEVEL_W-1:0];
                amr_fg_pkg::CFG_BASE_COLS: base_cols_reg <= cfg_wdata;
                amr_fg_pkg::CFG_BASE_ROWS: base_rows_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    logic                                  mem_we, mem_re;
    logic [2*FINE_SIDE_BITS-1:0]           mem_addr;
    logic [VALUE_BITS-1:0]                 mem_wdata, mem_rdata;
    amr_fg_pkg::acc_ctrl_t                 acc_ctrl;
    logic [amr_fg_pkg::SHIFT_W-1:0]        shift_amt;
    logic signed [amr_fg_pkg::MEAN_W-1:0]  acc_mean;
    amr_fg_pkg::done_t                     done;
    logic                                  out_free;

    logic                                  m_tvalid_reg;
    logic [31:0]                           m_tdata_reg;
    logic                                  m_tuser_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    amr_fg_walker #(
        .FINE_SIDE_BITS(FINE_SIDE_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_level  (max_level_reg),
        .base_cols  (base_cols_reg),
        .base_rows  (base_rows_reg),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item_mode  (s_tuser),
        .item_level (s_tdata[3:0]),
        .item_col   (s_tdata[11:4]),
        .item_row   (s_tdata[19:12]),
        .item_value (signed'(s_tdata[51:20])),
        .mem_we     (mem_we),
        .mem_re     (mem_re),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .acc_ctrl   (acc_ctrl),
        .shift_amt  (shift_amt),
        .out_free   (out_free),
        .done       (done)
    );

    amr_fg_store #(
        .FINE_SIDE_BITS(FINE_SIDE_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    amr_fg_accum #(
        .FINE_SIDE_BITS(FINE_SIDE_BITS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_accum (
        .aclk      (aclk),
        .ctrl      (acc_ctrl),
        .rd_data   (mem_rdata),
        .shift_amt (shift_amt),
        .mean      (acc_mean)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (done.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done.valid) begin
            // zero the mean for loads and for items in error
            m_tdata_reg <= (done.error || !done.query) ? '0 : acc_mean;
            m_tuser_reg <= done.error;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready the cycle after an item was accepted");

    a_error_mean_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("result in error carries a nonzero mean");

    a_done_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        done.valid |-> out_free)
        else $error("result finished while the output register was still full");

    a_no_access_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we || mem_re) |-> (!s_tready && !(mem_we && mem_re)))
        else $error("store accessed outside a walk or written and read at once");

endmodule

// ----- hdl/amr_fg_store.sv -----
// Fine-grid value store: one entry per finest-level cell, single port,
// registered read. Depends on nothing; the contents are undefined until written.
module amr_fg_store #(
    parameter int FINE_SIDE_BITS = 8,
    parameter int VALUE_BITS     = 32
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic                        re,
    input  logic [2*FINE_SIDE_BITS-1:0] addr,
    input  logic [VALUE_BITS-1:0]       wdata,
    output logic [VALUE_BITS-1:0]       rdata
);

    localparam int DEPTH = 1 << (2 * FINE_SIDE_BITS);

    logic [VALUE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- hdl/amr_fg_accum.sv -----
// Accumulator: adds one fine-cell value per cycle into a wide sum
// and forms the floor mean by an arithmetic shift. Depends on amr_fg_pkg.
module amr_fg_accum #(
    parameter int FINE_SIDE_BITS = 8,
    parameter int VALUE_BITS     = 32
) (
    input  logic                              aclk,
    input  amr_fg_pkg::acc_ctrl_t             ctrl,
    input  logic [VALUE_BITS-1:0]             rd_data,
    input  logic [amr_fg_pkg::SHIFT_W-1:0]    shift_amt,
    output logic signed [amr_fg_pkg::MEAN_W-1:0] mean
);

    // Exact sum width, capped at 64 where the sum wraps.
    localparam int SUM_W = (VALUE_BITS + 2 * FINE_SIDE_BITS > 64) ?
                           64 : VALUE_BITS + 2 * FINE_SIDE_BITS;

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [SUM_W-1:0] shifted;

    always_comb begin
        sum_next = sum_reg;
        if (ctrl.clear) begin
            sum_next = '0;
        end else if (ctrl.add) begin
            sum_next = sum_reg + SUM_W'(signed'(rd_data));
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign shifted = sum_reg >>> shift_amt;
    assign mean    = amr_fg_pkg::MEAN_W'(shifted);

endmodule

// ----- hdl/amr_fg_walker.sv -----
// Item sequencer: takes one item, checks its block against the grid, then, if in range,
// walks the covered fine cells one per cycle. Depends on amr_fg_pkg.
module amr_fg_walker #(
    parameter int FINE_SIDE_BITS = 8,
    parameter int VALUE_BITS     = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [amr_fg_pkg::LEVEL_W-1:0]        max_level,
    input  logic [amr_fg_pkg::BASE_W-1:0]         base_cols,
    input  logic [amr_fg_pkg::BASE_W-1:0]         base_rows,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  item_mode,
    input  logic [amr_fg_pkg::LEVEL_W-1:0]        item_level,
    input  logic [amr_fg_pkg::COORD_W-1:0]        item_col,
    input  logic [amr_fg_pkg::COORD_W-1:0]        item_row,
    input  logic signed [amr_fg_pkg::IN_VALUE_W-1:0] item_value,
    output logic                                  mem_we,
    output logic                                  mem_re,
    output logic [2*FINE_SIDE_BITS-1:0]           mem_addr,
    output logic [VALUE_BITS-1:0]                 mem_wdata,
    output amr_fg_pkg::acc_ctrl_t                 acc_ctrl,
    output logic [amr_fg_pkg::SHIFT_W-1:0]        shift_amt,
    input  logic                                  out_free,
    output amr_fg_pkg::done_t                     done
);

    localparam int FSB   = FINE_SIDE_BITS;
    localparam int POS_W = amr_fg_pkg::POS_W;
    localparam logic [POS_W-1:0] SIDE_LIMIT = POS_W'(1) << FINE_SIDE_BITS;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_WALK   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic                               mode_reg;
    logic [amr_fg_pkg::LEVEL_W-1:0]     level_reg;
    logic [amr_fg_pkg::COORD_W-1:0]     col_reg;
    logic [amr_fg_pkg::COORD_W-1:0]     row_reg;
    logic [VALUE_BITS-1:0]              value_reg;
    logic                               err_reg;
    logic                               add_reg;
    logic [amr_fg_pkg::SHIFT_W-1:0]     shift_reg;
    logic [FSB-1:0]                     x_reg, x0_reg, xlast_reg;
    logic [FSB-1:0]                     y_reg, ylast_reg;

    // Bounds check on the captured item.
    logic                               level_bad;
    logic [amr_fg_pkg::LEVEL_W-1:0]     k;
    logic [POS_W-1:0]                   side, x_base, y_base, x_end, y_end, gw, gh;
    logic [POS_W-1:0]                   x_last, y_last;
    logic                               chk_err;
    logic                               walk_end;

    always_comb begin
        level_bad = level_reg > max_level;
        k         = max_level - level_reg;
        side      = POS_W'(1) << k;
        x_base    = POS_W'(col_reg) << k;
        y_base    = POS_W'(row_reg) << k;
        x_end     = x_base + side;
        y_end     = y_base + side;
        x_last    = x_end - POS_W'(1);
        y_last    = y_end - POS_W'(1);
        gw        = POS_W'(base_cols) << max_level;
        gh        = POS_W'(base_rows) << max_level;
        chk_err   = level_bad || (x_end > gw) || (y_end > gh) ||
                    (x_end > SIDE_LIMIT) || (y_end > SIDE_LIMIT);
    end

    assign walk_end = (x_reg == xlast_reg) && (y_reg == ylast_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = chk_err ? ST_FINISH : ST_WALK;
            end
            ST_WALK: begin
                if (walk_end) begin
                    state_next = (mode_reg == amr_fg_pkg::MODE_QUERY) ? ST_DRAIN : ST_FINISH;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            add_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            add_reg   <= mem_re;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                mode_reg  <= item_mode;
                level_reg <= item_level;
                col_reg   <= item_col;
                row_reg   <= item_row;
                value_reg <= VALUE_BITS'(item_value);
            end
            ST_CHECK: begin
                err_reg   <= chk_err;
                shift_reg <= {k, 1'b0};
                x_reg     <= x_base[FSB-1:0];
                x0_reg    <= x_base[FSB-1:0];
                xlast_reg <= x_last[FSB-1:0];
                y_reg     <= y_base[FSB-1:0];
                ylast_reg <= y_last[FSB-1:0];
            end
            ST_WALK: begin
                // advance along the row, wrap to the next row at its far edge
                if (x_reg == xlast_reg) begin
                    x_reg <= x0_reg;
                    y_reg <= y_reg + FSB'(1);
                end else begin
                    x_reg <= x_reg + FSB'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign item_ready     = (state_reg == ST_IDLE);
    assign mem_we         = (state_reg == ST_WALK) && (mode_reg == amr_fg_pkg::MODE_LOAD);
    assign mem_re         = (state_reg == ST_WALK) && (mode_reg == amr_fg_pkg::MODE_QUERY);
    assign mem_addr       = {y_reg, x_reg};
    assign mem_wdata      = value_reg;
    assign acc_ctrl.clear = (state_reg == ST_CHECK);
    assign acc_ctrl.add   = add_reg;
    assign shift_amt      = shift_reg;
    assign done.valid     = (state_reg == ST_FINISH) && out_free;
    assign done.error     = err_reg;
    assign done.query     = (mode_reg == amr_fg_pkg::MODE_QUERY);

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for amr_fine_grid_remap_top: drives load and query items on the
// s_ stream and compares every m_ result with an in-bench model of the fine-grid store.
// Depends on amr_fg_pkg and amr_fine_grid_remap_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FINE_BITS   = 8;
    localparam int FINE_SIDE   = 1 << FINE_BITS;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 90;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [31:0] mean_value;
        logic        error;
        int unsigned seq;
    } remap_result_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_t;

    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [amr_fg_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [amr_fg_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [55:0]                       s_tdata   = '0;  // cell_level[3:0], col[11:4],
                                                        // row[19:12], cell_value[51:20]
    logic                              s_tuser   = 1'b0;  // mode
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [31:0]                       m_tdata;  // mean_value[31:0]
    logic                              m_tuser;  // error

    amr_fine_grid_remap_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Model state: the fine-grid store and the grid registers.
    logic [31:0]                     fine_cells [0:FINE_SIDE*FINE_SIDE-1];
    logic [amr_fg_pkg::LEVEL_W-1:0]  grid_max_level = '0;
    logic [amr_fg_pkg::BASE_W-1:0]   grid_cols      = 9'd1;
    logic [amr_fg_pkg::BASE_W-1:0]   grid_rows      = 9'd1;

    remap_result_t mean_queue [$];
    int mismatches = 0;
    int n_items    = 0;
    int n_loads    = 0;
    int n_queries  = 0;
    int n_rejects  = 0;
    int n_settings = 0;

    // Sender burst state
    bit offering    = 1'b0;
    int burst_left  = 0;
    int pending_gap = 1;

    // Receiver state
    int        hold_requests = 0;
    int        hold_served   = 0;
    int        hold_left     = 0;
    int        style_left    = 0;
    rx_style_t stall_style   = RX_OPEN;

    function automatic remap_result_t remap_cell(input logic mode, input logic [3:0] level,
                                                 input logic [7:0] col, input logic [7:0] row,
                                                 input logic [31:0] value);
        remap_result_t res;
        int            k;
        longint        side, x0, y0, gw, gh, x, y;
        longint signed total;
        res.mean_value = '0;
        res.error      = 1'b0;
        res.seq        = 0;
        if (level > grid_max_level) begin
            res.error = 1'b1;
            return res;
        end
        k    = int'(grid_max_level) - int'(level);
        side = longint'(1) << k;
        x0   = longint'(col) << k;
        y0   = longint'(row) << k;
        gw   = longint'(grid_cols) << grid_max_level;
        gh   = longint'(grid_rows) << grid_max_level;
        if (x0 + side > gw || y0 + side > gh || x0 + side > FINE_SIDE || y0 + side > FINE_SIDE) begin
            res.error = 1'b1;
            return res;
        end
        if (mode == amr_fg_pkg::MODE_LOAD) begin
            for (y = y0; y < y0 + side; y++)
                for (x = x0; x < x0 + side; x++)
                    fine_cells[int'((y << FINE_BITS) | x)] = value;
            return res;
        end
        total = 0;
        for (y = y0; y < y0 + side; y++)
            for (x = x0; x < x0 + side; x++)
                total += longint'(signed'(fine_cells[int'((y << FINE_BITS) | x)]));
        // floor division by 4^k
        res.mean_value = 32'(total >>> (2 * k));
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic send_cell(input logic mode, input logic [3:0] level, input logic [7:0] col,
                             input logic [7:0] row, input logic [31:0] value);
        remap_result_t res;
        if (!offering) begin
            repeat (pending_gap) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_tdata <= {4'b0, value, row, col, level};
        s_tuser <= mode;
        if (!offering)
            s_tvalid <= 1'b1;
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        res     = remap_cell(mode, level, col, row, value);
        res.seq = n_items;
        mean_queue.push_back(res);
        n_items++;
        if (res.error)
            n_rejects++;
        else if (mode == amr_fg_pkg::MODE_LOAD)
            n_loads++;
        else
            n_queries++;
        burst_left--;
        if (burst_left == 0) begin
            // zero gap: keep tvalid up and start the next burst right away
            pending_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (pending_gap == 0) begin
                burst_left = $urandom_range(1, 16);
            end else begin
                s_tvalid <= 1'b0;
                offering = 1'b0;
            end
        end
    endtask

    // Drop tvalid after the last item, then hold until every result is back.
    task automatic wait_drain();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        burst_left  = 0;
        pending_gap = 1;
        while (mean_queue.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_grid(input logic [3:0] ml, input logic [8:0] cols, input logic [8:0] rows);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= amr_fg_pkg::CFG_MAX_LEVEL;
        cfg_wdata <= amr_fg_pkg::CFG_W'(ml);
        @(posedge aclk);
        cfg_addr  <= amr_fg_pkg::CFG_BASE_COLS;
        cfg_wdata <= cols;
        @(posedge aclk);
        cfg_addr  <= amr_fg_pkg::CFG_BASE_ROWS;
        cfg_wdata <= rows;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        grid_max_level = ml;
        grid_cols      = cols;
        grid_rows      = rows;
        n_settings++;
    endtask

    // Registers at their reset values: a single fine cell.
    task automatic test_reset_settings();
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd0, 8'd0, 8'd0,   32'h0001_0000);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd0, 8'd0, 8'd0,   32'h0);
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd0, 8'd1, 8'd0,   32'h5555_5555);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd1, 8'd0, 8'd0,   32'h0);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd8, 8'd0, 8'd255, 32'h0);
    endtask

    // Fill the whole store with one coarse load, then probe signs and rounding.
    task automatic test_full_cover();
        set_grid(4'd8, 9'd1, 9'd1);
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd0, 8'd0,   8'd0,   32'hFFFE_8000);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd0, 8'd0,   8'd0,   32'h0);
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd8, 8'd255, 8'd255, 32'h7FFF_FFFF);
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd8, 8'd254, 8'd255, 32'h8000_0000);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd7, 8'd127, 8'd127, 32'h0);
        // a sum of -1 over four cells must floor to -1, not truncate to 0
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd8, 8'd0,   8'd0,   32'hFFFF_FFFF);
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd8, 8'd1,   8'd0,   32'h0);
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd8, 8'd0,   8'd1,   32'h0);
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd8, 8'd1,   8'd1,   32'h0);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd7, 8'd0,   8'd0,   32'h0);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd8, 8'd255, 8'd255, 32'h0);
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd0, 8'd0,   8'd1,   32'h1234_5678);
    endtask

    // Wide base runs into the store side; short base limits rows; zero base rejects all.
    task automatic test_grid_limits();
        set_grid(4'd4, 9'd256, 9'd3);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd0, 8'd15, 8'd2, 32'h0);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd0, 8'd16, 8'd0, 32'h0);
        send_cell(amr_fg_pkg::MODE_LOAD,  4'd0, 8'd0,  8'd3, 32'h0BAD_0BAD);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd5, 8'd0,  8'd0, 32'h0);
        set_grid(4'd4, 9'd0, 9'd3);
        send_cell(amr_fg_pkg::MODE_QUERY, 4'd4, 8'd0,  8'd0, 32'h0);
    endtask

    // One random item; loads are often followed by a query over the enclosing block.
    task automatic random_cell();
        logic [31:0] v;
        logic        mode;
        int          sel, k, kmax, lvl, lim_x, lim_y, j;
        logic [7:0]  c, r;
        case ($urandom_range(0, 9))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            3: v = 32'h0;
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 99) < 8) begin
            send_cell(1'($urandom_range(0, 1)), 4'($urandom_range(0, 8)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), v);
            return;
        end
        sel  = $urandom_range(0, 99);
        kmax = (sel < 70) ? 2 : (sel < 95) ? 4 : 6;
        if (kmax > int'(grid_max_level))
            kmax = int'(grid_max_level);
        k     = $urandom_range(0, kmax);
        lvl   = int'(grid_max_level) - k;
        lim_x = int'(grid_cols) << grid_max_level;
        lim_y = int'(grid_rows) << grid_max_level;
        if (lim_x > FINE_SIDE)
            lim_x = FINE_SIDE;
        if (lim_y > FINE_SIDE)
            lim_y = FINE_SIDE;
        lim_x = lim_x >> k;
        lim_y = lim_y >> k;
        c     = (lim_x > 0) ? 8'($urandom_range(0, lim_x - 1)) : 8'($urandom_range(0, 255));
        r     = (lim_y > 0) ? 8'($urandom_range(0, lim_y - 1)) : 8'($urandom_range(0, 255));
        mode  = 1'($urandom_range(0, 1));
        send_cell(mode, 4'(lvl), c, r, v);
        if (mode == amr_fg_pkg::MODE_LOAD && $urandom_range(0, 1) == 1) begin
            j = $urandom_range(0, (lvl < 2) ? lvl : 2);
            send_cell(amr_fg_pkg::MODE_QUERY, 4'(lvl - j), c >> j, r >> j, 32'h0);
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input backs up.
    task automatic test_output_stall();
        set_grid(4'd2, 9'd256, 9'd256);
        hold_requests++;
        repeat (14) random_cell();
        wait_drain();
    endtask

    task automatic test_random_remap();
        int fixed_ml   [6] = '{8, 8, 0, 3, 5, 1};
        int fixed_cols [6] = '{1, 256, 256, 256, 5, 1};
        int fixed_rows [6] = '{1, 256, 256, 1, 3, 256};
        int phase, first, ml, cols, rows;
        for (phase = 0; phase < 15; phase++) begin
            if (phase < 6) begin
                ml   = fixed_ml[phase];
                cols = fixed_cols[phase];
                rows = fixed_rows[phase];
            end else begin
                ml   = $urandom_range(0, 8);
                cols = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 256);
                rows = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 256);
            end
            set_grid(4'(ml), 9'(cols), 9'(rows));
            first = n_items;
            while (n_items - first < PHASE_ITEMS) begin
                // sender pause: let everything drain in the middle of a phase
                if (phase == 4 && n_items - first == PHASE_ITEMS / 2)
                    wait_drain();
                random_cell();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (style_left == 0) begin
            stall_style = rx_style_t'($urandom_range(0, 3));
            style_left  = $urandom_range(40, 200);
        end else begin
            style_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            case (stall_style)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= (style_left % 4 == 0);
                default:   m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        remap_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (mean_queue.size() == 0) begin
                report_mismatch($sformatf("result %h/%b with no item pending", m_tdata, m_tuser));
            end else begin
                want = mean_queue.pop_front();
                if (m_tdata !== want.mean_value)
                    report_mismatch($sformatf("item %0d mean_value got %h want %h",
                                              want.seq, m_tdata, want.mean_value));
                if (m_tuser !== want.error)
                    report_mismatch($sformatf("item %0d error got %b want %b",
                                              want.seq, m_tuser, want.error));
            end
        end
    end

    initial begin
        #(64'd40_000_000);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_settings();
        test_full_cover();
        test_grid_limits();
        test_output_stall();
        test_random_remap();
        wait_drain();
        repeat (20) @(posedge aclk);
        if (mean_queue.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", mean_queue.size()));
        $display("Ran %0d items over %0d grid settings: %0d loads, %0d queries, %0d rejected.",
                 n_items, n_settings, n_loads, n_queries, n_rejects);
        $display("Output stalls, input back-pressure and a full drain were exercised.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
